// File: src/pig_pkg.sv
`timescale 1ns / 1ps
// shared types and codes for the primitive index generator
// no dependencies; imported by pig_ctrl, pig_datapath and the top level
package pig_pkg;

  // defaults for the top level parameters
  localparam int MAX_VERTS_DEF  = 32;
  localparam int INDEX_BITS_DEF = 16;

  // width of the index fields on the result channel
  localparam int OUT_W = 16;

  // hard cap on the primitives one command may yield
  localparam int RESULT_CAP = 32;

  // command codes
  localparam logic [1:0] CMD_ADD   = 2'd0;
  localparam logic [1:0] CMD_MULTI = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  // topology register codes
  localparam logic [1:0] TOPO_TRI   = 2'd0;
  localparam logic [1:0] TOPO_LINE  = 2'd1;
  localparam logic [1:0] TOPO_POINT = 2'd2;

  // corner counts
  localparam logic [1:0] CORNERS_POINT = 2'd1;
  localparam logic [1:0] CORNERS_LINE  = 2'd2;
  localparam logic [1:0] CORNERS_TRI   = 2'd3;

  // emission patterns
  localparam logic [2:0] MODE_FAN_DESC = 3'd0; // (0, d, d-1), d falling
  localparam logic [2:0] MODE_FAN_SWAP = 3'd1; // (0, d-1, d), d falling
  localparam logic [2:0] MODE_FAN_ASC  = 3'd2; // (0, k+2, k+1)
  localparam logic [2:0] MODE_SPHERE   = 3'd3; // ring strip plus two closing triangles
  localparam logic [2:0] MODE_LINE     = 3'd4; // (k, k+1)
  localparam logic [2:0] MODE_POINT    = 3'd5; // (k)

  // controller to datapath
  typedef struct packed {
    logic load;    // input beat taken
    logic step;    // result beat taken, more to come
    logic finish;  // final result beat taken
  } pig_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic start;   // decoded command yields at least one primitive
    logic last;    // current primitive is the final one
  } pig_stat_t;

endpackage

// File: src/pig_ctrl.sv
`timescale 1ns / 1ps
// control state machine of the primitive index generator
// depends on pig_pkg for the command and status structs
module pig_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  pig_pkg::pig_stat_t  stat,
  output pig_pkg::pig_cmd_t   cmd
);
  import pig_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_RUN  = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (stat.start) begin
            state_next = S_RUN;
          end
        end
      end
      S_RUN: begin
        out_valid = 1'b1;
        if (!out_stall) begin
          if (stat.last) begin
            cmd.finish = 1'b1;
            state_next = S_IDLE;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // final beat returns to idle
  a_last_to_idle: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && stat.last) |=> (state == S_IDLE))
    else $error("controller did not return to idle after the final beat");

  // a command with work starts emitting
  a_start_run: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && stat.start) |=> (state == S_RUN))
    else $error("command with primitives did not start emitting");

  // a stalled result is held
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_RUN && out_stall) |=> (state == S_RUN && !cmd.load))
    else $error("result dropped while stalled");

endmodule

// File: src/pig_datapath.sv
`timescale 1ns / 1ps
// datapath: command decode, vertex base, step counter and index arithmetic
// depends on pig_pkg for codes and the command and status structs
module pig_datapath #(
  parameter int MAX_VERTS  = pig_pkg::MAX_VERTS_DEF,
  parameter int INDEX_BITS = pig_pkg::INDEX_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_data,
  input  logic [1:0]          command,
  input  logic [5:0]          vertex_count,
  input  logic                sphere_hint,
  input  logic                ccw,
  input  pig_pkg::pig_cmd_t   cmd,
  output pig_pkg::pig_stat_t  stat,
  output logic [15:0]         index_a,
  output logic [15:0]         index_b,
  output logic [15:0]         index_c,
  output logic [1:0]          corners,
  output logic                last
);
  import pig_pkg::*;

  localparam int LIM    = (MAX_VERTS < RESULT_CAP) ? MAX_VERTS : RESULT_CAP;
  localparam int CNT_W  = $clog2(LIM + 1);
  localparam int BASE_W = (INDEX_BITS < OUT_W) ? INDEX_BITS : OUT_W;

  logic [1:0]        topology;
  logic [BASE_W-1:0] vertex_base;
  logic [2:0]        mode;
  logic [CNT_W-1:0]  n_r;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  adv_r;
  logic [CNT_W-1:0]  k;

  // decode of the incoming command
  logic [CNT_W-1:0]  nsat;
  logic [CNT_W-1:0]  sph_cnt;
  logic [2:0]        dec_mode;
  logic [CNT_W-1:0]  dec_count;
  logic [CNT_W-1:0]  dec_adv;
  logic              dec_clear;

  always_comb begin
    nsat      = (vertex_count > 6'(LIM)) ? CNT_W'(LIM) : CNT_W'(vertex_count);
    sph_cnt   = ((nsat - CNT_W'(2)) & ~CNT_W'(1)) + CNT_W'(2);
    dec_mode  = MODE_POINT;
    dec_count = '0;
    dec_adv   = '0;
    dec_clear = 1'b0;
    case (command)
      CMD_CLEAR: begin
        dec_clear = 1'b1;
      end
      CMD_MULTI: begin
        if (topology == TOPO_TRI) begin
          dec_mode  = ccw ? MODE_FAN_DESC : MODE_FAN_SWAP;
          dec_adv   = nsat;
          dec_count = (nsat >= CNT_W'(3)) ? nsat - CNT_W'(2) : '0;
        end
      end
      CMD_ADD: begin
        case (topology)
          TOPO_TRI: begin
            if (nsat >= CNT_W'(3)) begin
              if (sphere_hint) begin
                dec_mode  = MODE_SPHERE;
                dec_count = sph_cnt;
                dec_adv   = sph_cnt;
              end else begin
                dec_mode  = ccw ? MODE_FAN_ASC : MODE_FAN_DESC;
                dec_count = nsat - CNT_W'(2);
                dec_adv   = nsat;
              end
            end
          end
          TOPO_LINE: begin
            if (nsat >= CNT_W'(2)) begin
              dec_mode  = MODE_LINE;
              dec_count = nsat - CNT_W'(1);
              dec_adv   = nsat;
            end
          end
          TOPO_POINT: begin
            dec_mode  = MODE_POINT;
            dec_count = nsat;
            dec_adv   = nsat;
          end
          default: begin
            dec_count = '0;
          end
        endcase
      end
      default: begin
        dec_count = '0;
      end
    endcase
  end

  assign stat.start = (dec_count != '0);
  assign stat.last  = (k == count_r - CNT_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      topology    <= TOPO_TRI;
      vertex_base <= '0;
    end else begin
      if (cfg_we) begin
        topology <= cfg_data;
      end
      if (cmd.load && dec_count == '0) begin
        vertex_base <= dec_clear ? '0 : vertex_base + BASE_W'(dec_adv);
      end else if (cmd.finish) begin
        vertex_base <= vertex_base + BASE_W'(adv_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mode    <= dec_mode;
      n_r     <= nsat;
      count_r <= dec_count;
      adv_r   <= dec_adv;
      k       <= '0;
    end else if (cmd.step) begin
      k <= k + CNT_W'(1);
    end
  end

  // tuple offsets for the current step
  logic [CNT_W-1:0] d;
  logic [CNT_W-1:0] off_a;
  logic [CNT_W-1:0] off_b;
  logic [CNT_W-1:0] off_c;
  logic             use_b;
  logic             use_c;

  always_comb begin
    d       = n_r - CNT_W'(1) - k;
    off_a   = '0;
    off_b   = '0;
    off_c   = '0;
    use_b   = 1'b1;
    use_c   = 1'b1;
    corners = CORNERS_TRI;
    case (mode)
      MODE_FAN_DESC: begin
        off_b = d;
        off_c = d - CNT_W'(1);
      end
      MODE_FAN_SWAP: begin
        off_b = d - CNT_W'(1);
        off_c = d;
      end
      MODE_FAN_ASC: begin
        off_b = k + CNT_W'(2);
        off_c = k + CNT_W'(1);
      end
      MODE_SPHERE: begin
        if (stat.last) begin
          off_a = CNT_W'(1);
          off_c = n_r - CNT_W'(1);
        end else if (k == count_r - CNT_W'(2)) begin
          off_b = n_r - CNT_W'(2);
          off_c = n_r - CNT_W'(1);
        end else if (k[0]) begin
          off_a = k + CNT_W'(2);
          off_b = k + CNT_W'(1);
          off_c = k;
        end else begin
          off_a = k + CNT_W'(2);
          off_b = k;
          off_c = k + CNT_W'(1);
        end
      end
      MODE_LINE: begin
        off_a   = k;
        off_b   = k + CNT_W'(1);
        use_c   = 1'b0;
        corners = CORNERS_LINE;
      end
      MODE_POINT: begin
        off_a   = k;
        use_b   = 1'b0;
        use_c   = 1'b0;
        corners = CORNERS_POINT;
      end
      default: begin
        off_a = '0;
      end
    endcase
  end

  logic [BASE_W-1:0] sum_a;
  logic [BASE_W-1:0] sum_b;
  logic [BASE_W-1:0] sum_c;

  assign sum_a   = vertex_base + BASE_W'(off_a);
  assign sum_b   = vertex_base + BASE_W'(off_b);
  assign sum_c   = vertex_base + BASE_W'(off_c);
  assign index_a = OUT_W'(sum_a);
  assign index_b = use_b ? OUT_W'(sum_b) : '0;
  assign index_c = use_c ? OUT_W'(sum_c) : '0;
  assign last    = stat.last;

endmodule

// File: src/primitive_index_generator_top.sv
`timescale 1ns / 1ps
// top level of the primitive index generator: ports, config handshake, wiring
// depends on pig_pkg, pig_ctrl and pig_datapath
//
// channel   direction  handshake            payload
// in        input      in_valid / in_stall  command, vertex_count, sphere_hint, ccw
// out       output     out_valid/out_stall  index_a, index_b, index_c, corners, last
// cfg       input      cfg_valid/cfg_ready  cfg_data (topology)
//
// a command is accepted while idle, then its P primitives go out one per cycle
// while out_stall is low (P at most 32), counted by the step counter
// commands that yield nothing complete in their accept cycle
// rst is synchronous: topology returns to triangle list, vertex base to zero
// a stall on the result side holds the current primitive and its indices
// in_stall stays high from the accept until the final result beat is taken
module primitive_index_generator_top #(
  parameter int MAX_VERTS  = pig_pkg::MAX_VERTS_DEF,
  parameter int INDEX_BITS = pig_pkg::INDEX_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_data,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [5:0]  vertex_count,
  input  logic        sphere_hint,
  input  logic        ccw,
  // primitive channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] index_a,
  output logic [15:0] index_b,
  output logic [15:0] index_c,
  output logic [1:0]  corners,
  output logic        last
);
  import pig_pkg::*;

  pig_cmd_t  cmd;
  pig_stat_t stat;

  // topology may be written at any time the block is idle
  assign cfg_ready = 1'b1;

  // sequencing: idle / emitting
  pig_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // decode, base register and per-step index arithmetic
  pig_datapath #(
    .MAX_VERTS  (MAX_VERTS),
    .INDEX_BITS (INDEX_BITS)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid & cfg_ready),
    .cfg_data     (cfg_data),
    .command      (command),
    .vertex_count (vertex_count),
    .sphere_hint  (sphere_hint),
    .ccw          (ccw),
    .cmd          (cmd),
    .stat         (stat),
    .index_a      (index_a),
    .index_b      (index_b),
    .index_c      (index_c),
    .corners      (corners),
    .last         (last)
  );

endmodule
